@@ rtl/cma_pkg.sv @@
package cma_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int CFG_W               = 6;
  localparam int HALF_WINDOW_RESET   = 1;
  localparam int MAX_HALF_WINDOW_DEF = 32;
  // must stay a power of two, pointers wrap by truncation
  localparam int JOBQ_DEPTH          = 4;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;
  } cma_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   last_average;
  } cma_out_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_CHK,
    F_SUB
  } front_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

endpackage

@@ rtl/cma_front.sv @@
module cma_front #(
  parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_WINDOW_DEF,
  localparam int PW    = $clog2(MAX_HALF_WINDOW + 1),
  localparam int WIN_W = PW + 1,
  localparam int RING  = 2 * MAX_HALF_WINDOW,
  localparam int AW    = (RING > 1) ? $clog2(RING) : 1,
  localparam int SUM_W = cma_pkg::SAMPLE_BITS + AW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [cma_pkg::CFG_W-1:0] cfg_data,
  input  logic                     push,
  input  cma_pkg::cma_in_t         item,
  output logic                     full,
  output logic                     job_push,
  output logic [SUM_W-1:0]         job_sum,
  output logic [WIN_W-1:0]         job_len,
  output logic                     job_last,
  input  logic                     q_full
);
  import cma_pkg::*;

  localparam int AW1 = AW + 1;

  front_state_t state, state_next;

  logic [CFG_W-1:0]       half_cfg;
  logic [PW-1:0]          p_cfg, p_use, p_act;
  logic [WIN_W-1:0]       win_use, win;
  logic [AW-1:0]          wp, wp_inc, rd_addr;
  logic [SAMPLE_BITS-1:0] ring [RING];
  logic [SAMPLE_BITS-1:0] rd_data, x_reg;
  logic                   last_reg;
  logic [SUM_W-1:0]       sum, sum_sub, sum_new;
  logic [WIN_W-1:0]       seen, seen_new, pending;
  logic [PW-1:0]          nout, fl_d;
  logic [WIN_W-1:0]       fl_len, dp, w;
  logic                   full_win, emit, need_sub, accept;

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] base,
                                              input logic [WIN_W-1:0] off);
    logic [AW1-1:0] t;
    t = {1'b0, base} + AW1'(WIN_W'(RING) - off);
    if (t >= AW1'(RING)) t = t - AW1'(RING);
    return t[AW-1:0];
  endfunction

  always_comb begin
    if (half_cfg == '0) begin
      p_cfg = PW'(1);
    end else if (half_cfg > CFG_W'(MAX_HALF_WINDOW)) begin
      p_cfg = PW'(MAX_HALF_WINDOW);
    end else begin
      p_cfg = PW'(half_cfg);
    end
  end

  assign p_use   = (seen == '0) ? p_cfg : p_act;
  assign win_use = {p_use, 1'b0};
  assign win     = {p_act, 1'b0};
  assign wp_inc  = (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);

  assign full   = (state != F_IDLE) || q_full;
  assign accept = push && !full;

  // update of the running sum once the outgoing sample has been read
  assign full_win = seen >= win;
  assign sum_sub  = full_win ? sum - SUM_W'(rd_data) : sum;
  assign sum_new  = sum_sub + SUM_W'(x_reg);
  assign seen_new = full_win ? seen : seen + WIN_W'(1);
  assign pending  = seen_new - WIN_W'(nout);
  assign emit     = !last_reg && (pending >= WIN_W'(p_act));

  // flush: window end shrinks by one per result, trim oldest sample
  assign dp       = WIN_W'(fl_d) + WIN_W'(p_act);
  assign w        = (dp > seen) ? seen : dp;
  assign need_sub = fl_len > w;

  always_comb begin
    if (state == F_IDLE) begin
      rd_addr = ring_back(wp, win_use);
    end else begin
      rd_addr = ring_back(wp, fl_len - WIN_W'(1));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_UPD;
      F_UPD:  state_next = last_reg ? F_CHK : F_IDLE;
      F_CHK: begin
        if (need_sub) begin
          state_next = F_SUB;
        end else if (!q_full && fl_d == PW'(1)) begin
          state_next = F_IDLE;
        end
      end
      F_SUB:  state_next = F_CHK;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    job_push = 1'b0;
    job_sum  = sum_new;
    job_len  = seen_new;
    job_last = 1'b0;
    case (state)
      F_UPD: job_push = emit;
      F_CHK: begin
        job_push = !need_sub && !q_full;
        job_sum  = sum;
        job_len  = fl_len;
        job_last = fl_d == PW'(1);
      end
      default: job_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
    if (state == F_UPD) ring[wp] <= x_reg;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg    <= item.sample;
      last_reg <= item.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      half_cfg <= CFG_W'(HALF_WINDOW_RESET);
      p_act    <= PW'(1);
      wp       <= '0;
      sum      <= '0;
      seen     <= '0;
      nout     <= '0;
      fl_d     <= '0;
      fl_len   <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) half_cfg <= cfg_data;
      case (state)
        F_IDLE: begin
          if (accept && seen == '0) p_act <= p_cfg;
        end
        F_UPD: begin
          sum  <= sum_new;
          seen <= seen_new;
          if (last_reg) begin
            fl_d   <= PW'(pending);
            fl_len <= seen_new;
          end else begin
            wp <= wp_inc;
            if (emit && nout < p_act) nout <= nout + PW'(1);
          end
        end
        F_CHK: begin
          if (!need_sub && !q_full) begin
            fl_d <= fl_d - PW'(1);
            if (fl_d == PW'(1)) begin
              sum  <= '0;
              seen <= '0;
              nout <= '0;
              wp   <= '0;
            end
          end
        end
        F_SUB: begin
          sum    <= sum - SUM_W'(rd_data);
          fl_len <= fl_len - WIN_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    state == F_UPD |-> pending <= WIN_W'(p_act))
    else $error("pending positions exceed half window");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= win)
    else $error("sample count beyond window");

  a_flush_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == F_CHK |-> (fl_len != '0 && fl_d != '0))
    else $error("flush step with empty window or no position left");

endmodule

@@ rtl/cma_jobq.sv @@
module cma_jobq #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);
  import cma_pkg::*;

  localparam int DEPTH = JOBQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/cma_div.sv @@
module cma_div #(
  parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_WINDOW_DEF,
  localparam int PW    = $clog2(MAX_HALF_WINDOW + 1),
  localparam int WIN_W = PW + 1,
  localparam int RING  = 2 * MAX_HALF_WINDOW,
  localparam int AW    = (RING > 1) ? $clog2(RING) : 1,
  localparam int SUM_W = cma_pkg::SAMPLE_BITS + AW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [SUM_W-1:0]   job_sum,
  input  logic [WIN_W-1:0]   job_len,
  input  logic               job_last,
  output cma_pkg::cma_out_t  result,
  output logic               empty,
  input  logic               pop
);
  import cma_pkg::*;

  localparam int CW = $clog2(SUM_W + 1);

  div_state_t state, state_next;

  logic [SUM_W-1:0] quo, quo_nx;
  logic [WIN_W-1:0] rem, rem_nx, dlen;
  logic [WIN_W:0]   rem_sh;
  logic             ge, dlast;
  logic [CW-1:0]    cnt;
  cma_out_t         res;
  logic             res_valid, res_load;

  // restoring long division, one quotient bit per cycle
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dlen};
  assign rem_nx = ge ? WIN_W'(rem_sh - {1'b0, dlen}) : WIN_W'(rem_sh);
  assign quo_nx = {quo[SUM_W-2:0], ge};

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: if (!q_empty) state_next = D_RUN;
      D_RUN:  if (cnt == CW'(1)) state_next = D_DONE;
      D_DONE: if (!res_valid || pop) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    case (state)
      D_IDLE:  q_pop = !q_empty;
      D_DONE:  res_load = !res_valid || pop;
      default: q_pop = 1'b0;
    endcase
  end

  assign empty  = !res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo   <= job_sum;
      rem   <= '0;
      dlen  <= job_len;
      dlast <= job_last;
    end else if (state == D_RUN) begin
      quo <= quo_nx;
      rem <= rem_nx;
    end
    if (res_load) begin
      res.average      <= quo[SAMPLE_BITS-1:0];
      res.last_average <= dlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= D_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= CW'(SUM_W);
      end else if (state == D_RUN) begin
        cnt <= cnt - CW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    state == D_RUN |-> cnt != '0)
    else $error("divider running with no bits left");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == D_RUN |-> (dlen != '0 && rem < dlen))
    else $error("partial remainder not below divisor");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    state == D_DONE |-> quo[SUM_W-1:SAMPLE_BITS] == '0)
    else $error("mean wider than a sample");

endmodule

@@ rtl/centered_moving_average_top.sv @@
// channel   direction  handshake              beat
// item      in         push / full            sample, last_sample
// result    out        pop / empty            average, last_average
// cfg       in         cfg_valid / cfg_ready  half_window (6 bits)
//
// Front end accepts a sample, then updates the ring and sum in F_UPD; a last
// sample adds F_CHK/F_SUB steps per flushed position. Each result goes through
// the bit-serial divider, which sets the sustained result rate and takes a new
// job only once the last one is done. A 4-entry job queue sits between
// front and divider; the result register lets the divider start the next job
// while a result waits. Reset is synchronous and clears all control state; the
// sample ring needs no clearing.
module centered_moving_average_top #(
  parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cma_pkg::CFG_W-1:0] cfg_data,
  input  logic                      push,
  output logic                      full,
  input  cma_pkg::cma_in_t          item,
  input  logic                      pop,
  output logic                      empty,
  output cma_pkg::cma_out_t         result
);
  import cma_pkg::*;

  localparam int PW     = $clog2(MAX_HALF_WINDOW + 1);
  localparam int WIN_W  = PW + 1;
  localparam int RING   = 2 * MAX_HALF_WINDOW;
  localparam int AW     = (RING > 1) ? $clog2(RING) : 1;
  localparam int SUM_W  = SAMPLE_BITS + AW;
  localparam int JOB_W  = SUM_W + WIN_W + 1;

  logic             job_push, job_last, q_full, q_empty, q_pop;
  logic [SUM_W-1:0] job_sum;
  logic [WIN_W-1:0] job_len;
  logic [JOB_W-1:0] q_out;

  assign cfg_ready = 1'b1;

  cma_front #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .job_push (job_push),
    .job_sum  (job_sum),
    .job_len  (job_len),
    .job_last (job_last),
    .q_full   (q_full)
  );

  cma_jobq #(
    .DATA_W(JOB_W)
  ) u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_data({job_sum, job_len, job_last}),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_out),
    .empty  (q_empty)
  );

  cma_div #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .job_sum (q_out[JOB_W-1:WIN_W+1]),
    .job_len (q_out[WIN_W:1]),
    .job_last(q_out[0]),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

@@ test/centered_moving_average_top_test.sv @@
`timescale 1ns / 100ps

module centered_moving_average_top_test;
  import cma_pkg::*;

  localparam int RING_SLOTS    = 2 * MAX_HALF_WINDOW_DEF;
  localparam int SLOT_W        = $clog2(RING_SLOTS);
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 93;
  localparam int N_ROWS        = 27;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
    logic                   typed;
    logic [SAMPLE_BITS-1:0] exp_avg;
    logic                   exp_last;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;
  logic              push;
  logic              full;
  cma_in_t           item;
  logic              pop = 1'b0;
  logic              empty;
  cma_out_t          result;

  centered_moving_average_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  always #6 clk = ~clk;

  // sliding-window state, mirrors the block
  logic [SAMPLE_BITS-1:0] ring [RING_SLOTS];
  logic [21:0]            window_sum = '0;
  int unsigned            filled = 0;
  int unsigned            emitted = 0;
  int unsigned            wr_slot = 0;
  int unsigned            seq_half = 1;
  logic [CFG_W-1:0]       half_window_reg = CFG_W'(HALF_WINDOW_RESET);

  cma_out_t expected_averages [$];

  int unsigned err_count = 0;
  int unsigned samples_sent = 0;
  int unsigned averages_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned full_stalls = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  bit          pressure_go = 1'b0;
  bit          hold_pop = 1'b0;

  logic [7:0]  pop_mask = 8'hFF;
  int unsigned mask_age = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_ITEM, 16'd65535, 1'b1, 1'b1, 16'd65535, 1'b1},  // one-sample sequence
    '{ROW_ITEM, 16'd0,     1'b1, 1'b1, 16'd0,     1'b1},
    '{ROW_ITEM, 16'd65535, 1'b0, 1'b1, 16'd65535, 1'b0},
    '{ROW_ITEM, 16'd65535, 1'b1, 1'b1, 16'd65535, 1'b1},
    '{ROW_ITEM, 16'd0,     1'b0, 1'b1, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd1,     1'b1, 1'b1, 16'd0,     1'b1},
    '{ROW_CFG,  16'd0,     1'b0, 1'b0, 16'd0,     1'b0},  // zero behaves as one
    '{ROW_ITEM, 16'd40000, 1'b0, 1'b1, 16'd40000, 1'b0},
    '{ROW_ITEM, 16'd20000, 1'b1, 1'b1, 16'd30000, 1'b1},
    '{ROW_CFG,  16'd63,    1'b0, 1'b0, 16'd0,     1'b0},  // clamps to max
    '{ROW_ITEM, 16'd100,   1'b0, 1'b0, 16'd0,     1'b0},  // sequence shorter than window
    '{ROW_ITEM, 16'd200,   1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd300,   1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,  16'd2,     1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd1000,  1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd2000,  1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,  16'd5,     1'b0, 1'b0, 16'd0,     1'b0},  // mid-sequence, latched later
    '{ROW_ITEM, 16'd3000,  1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd4000,  1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,  16'd33,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'hAAAA,  1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'h5555,  1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,  16'd32,    1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
    '{ROW_ITEM, 16'd65535, 1'b1, 1'b0, 16'd0,     1'b0},
    '{ROW_CFG,  16'd1,     1'b0, 1'b0, 16'd0,     1'b0}
  };

  function automatic int unsigned clamp_half(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_HALF_WINDOW_DEF) return MAX_HALF_WINDOW_DEF;
    return 32'(v);
  endfunction

  // window means caused by one accepted sample
  task automatic compute_averages(input logic [SAMPLE_BITS-1:0] x, input logic is_last);
    int unsigned p, span, cur, owed, len, reach;
    int          d;
    logic [21:0] sum;
    cma_out_t    r;
    if (filled == 0) seq_half = clamp_half(half_window_reg);
    p = seq_half;
    span = 2 * p;
    if (filled >= span)
      window_sum -= 22'(ring[SLOT_W'((wr_slot + RING_SLOTS - span) % RING_SLOTS)]);
    else
      filled++;
    cur = wr_slot % RING_SLOTS;
    ring[SLOT_W'(cur)] = x;
    window_sum += 22'(x);
    wr_slot = (cur + 1) % RING_SLOTS;
    owed = filled - emitted;
    if (!is_last) begin
      if (owed >= p) begin
        r.average = SAMPLE_BITS'(window_sum / filled);
        r.last_average = 1'b0;
        expected_averages.push_back(r);
        if (emitted < p) emitted++;
      end
    end else begin
      sum = window_sum;
      len = filled;
      // flush: shrink the window from the oldest side as positions near the end
      for (d = owed; d >= 1; d--) begin
        reach = d + p;
        if (reach > filled) reach = filled;
        while (len > reach) begin
          sum -= 22'(ring[SLOT_W'((cur + RING_SLOTS - (len - 1)) % RING_SLOTS)]);
          len--;
        end
        r.average = (len != 0) ? SAMPLE_BITS'(sum / len) : '0;
        r.last_average = (d == 1);
        expected_averages.push_back(r);
      end
      window_sum = '0;
      filled = 0;
      emitted = 0;
      wr_slot = 0;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        @(negedge clk) push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    item <= '{sample: s, last_sample: is_last};
    forever begin
      @(posedge clk);
      if (!full) break;
      full_stalls++;
    end
    compute_averages(s, is_last);
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) push <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    // a sample with no result may still be in the front end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_window(input logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    half_window_reg = v;
    cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_result
    cma_out_t want;
    if (!rst && pop && !empty) begin
      if (expected_averages.size() == 0) begin
        $error("unexpected beat: average %0d last_average %0d",
               result.average, result.last_average);
        err_count++;
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (result.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, result.average);
          err_count++;
        end
        if (result.last_average !== want.last_average) begin
          $error("last_average: expected %0d, got %0d",
                 want.last_average, result.last_average);
          err_count++;
        end
      end
    end
  end

  // receiver stall pattern, reloaded when its random age counter runs out
  always @(negedge clk) begin
    if (mask_age == 0) begin
      mask_age <= $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       pop_mask <= 8'hFF;
        1:       pop_mask <= 8'($urandom);
        default: pop_mask <= 8'($urandom) | 8'h11;
      endcase
    end else begin
      mask_age <= mask_age - 1;
      pop_mask <= {pop_mask[6:0], pop_mask[7]};
    end
    pop <= !hold_pop && pop_mask[0];
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_pop = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("centered_moving_average_top_test failed");
    $finish;
  end

  initial begin
    int unsigned rand_items, phase_no, p_eff, n_seq, seq_len, drain;
    logic [CFG_W-1:0]       cfg_val;
    logic [SAMPLE_BITS-1:0] s;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_half_window(CFG_W'(directed_rows[i].value));
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].last);
        if (directed_rows[i].typed)
          expected_averages[expected_averages.size() - 1] =
            '{average: directed_rows[i].exp_avg, last_average: directed_rows[i].exp_last};
      end
    end

    rand_items = 0;
    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (phase_no == 0) cfg_val = CFG_W'(1);
      else begin
        case ($urandom_range(0, 7))
          0:       cfg_val = CFG_W'(0);
          1:       cfg_val = CFG_W'(32);
          2:       cfg_val = CFG_W'($urandom_range(33, 63));
          3:       cfg_val = CFG_W'($urandom_range(9, 32));
          default: cfg_val = CFG_W'($urandom_range(1, 8));
        endcase
      end
      write_half_window(cfg_val);
      p_eff = clamp_half(cfg_val);
      steady = ($urandom_range(0, 3) == 0);
      n_seq = (phase_no == 0) ? 1 : $urandom_range(1, 3);
      if (phase_no == 0) pressure_go = 1'b1;
      for (int q = 0; q < n_seq; q++) begin
        if (rand_items >= RANDOM_ITEMS) break;
        if (phase_no == 0) seq_len = 30;
        else if ($urandom_range(0, 4) == 0) seq_len = $urandom_range(1, p_eff);
        else seq_len = $urandom_range(1, 2 * p_eff + 3);
        // cap the total at the planned item count
        if (seq_len > RANDOM_ITEMS - rand_items) seq_len = RANDOM_ITEMS - rand_items;
        for (int k = 0; k < seq_len; k++) begin
          case ($urandom_range(0, 7))
            0:       s = '0;
            1:       s = '1;
            default: s = SAMPLE_BITS'($urandom);
          endcase
          send_sample(s, k == seq_len - 1);
          rand_items++;
        end
      end
      phase_no++;
    end

    @(negedge clk) push <= 1'b0;
    drain = 0;
    while (expected_averages.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_averages.size() != 0) begin
      $error("%0d expected averages never arrived", expected_averages.size());
      err_count++;
    end

    $display("covered %0d samples over %0d half-window settings, %0d averages checked",
             samples_sent, cfg_writes, averages_checked);
    $display("input held off by full for %0d cycles", full_stalls);
    if (err_count == 0)
      $display("centered_moving_average_top_test passed");
    else
      $display("centered_moving_average_top_test failed");
    $finish;
  end

endmodule
